// File: rtl/cldf_pkg.sv
// Shared types, sizes and helpers for the credit limited dispatch FIFO.
// No dependencies; used by credit_limited_dispatch_fifo.sv.
package cldf_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int RECORD_WIDTH = 64;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W  = 7;
    localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
    localparam int WORD_W = 64;
    localparam int STAT_W = 3;
    localparam int RES_W  = WORD_W + 3 * CNT_W;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W  = TDATA_W - RES_W;
    localparam int ADDR_W = 3;
    localparam int APB_W  = 32;

    localparam logic [CNT_W-1:0] CEILING_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_CEILING = 1'b0;

    typedef enum logic [2:0] {
        CMD_ADMIT   = 3'd0,
        CMD_TAKE    = 3'd1,
        CMD_SETTLE  = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_CLOSE   = 3'd4,
        CMD_DISCARD = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_OVERFLOW     = 3'd1,
        ST_STOPPED      = 3'd2,
        ST_CLOSED_EMPTY = 3'd3,
        ST_EMPTY_RETRY  = 3'd4
    } status_t;

    typedef struct packed {
        status_t          status;
        logic             take_ok;
        logic [CNT_W-1:0] outstanding;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] dropped;
    } meta_t;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

// File: rtl/cldf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cldf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/credit_limited_dispatch_fifo.sv
// Credit limited dispatch FIFO: record queue in a RAM, outstanding count bounded by ceiling.
// Depends on cldf_pkg and cldf_ram.
//
//  port group   dir  beat contents (low bit first)
//  s_*          in   tuser: cmd[2:0]; tdata: record_word[63:0]
//  m_*          out  tuser: status[2:0]; tdata: record_out, outstanding_count,
//                    queue_fill, dropped_count, zero pad
//  apb          in   ceiling at byte address 0
//
// One beat per cycle while the output drains; a taken beat goes through the read stage
// (RAM read at the accepting edge) and then loads into the output register.
// Counters and pointers update at acceptance, so back to back commands see each other.
// Reset clears pointers, counts and flags; ceiling returns to 64; RAM is not cleared.
// A stalled output holds its beat, the read stage stays full and s_tready drops.
module credit_limited_dispatch_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cldf_pkg::WORD_W-1:0]   s_tdata,  // record_word[63:0]
    input  logic [2:0]                    s_tuser,  // cmd[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // record_out[63:0], outstanding_count[70:64], queue_fill[77:71],
    // dropped_count[84:78], zero pad
    output logic [cldf_pkg::TDATA_W-1:0]  m_tdata,
    output logic [2:0]                    m_tuser,  // status[2:0]
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cldf_pkg::ADDR_W-1:0]   paddr,
    input  logic [cldf_pkg::APB_W-1:0]    pwdata,
    output logic [cldf_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);

    localparam int PW = cldf_pkg::PTR_W;
    localparam int FW = cldf_pkg::FILL_W;
    localparam int CW = cldf_pkg::CNT_W;
    localparam int RW = cldf_pkg::RECORD_WIDTH;

    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     outstanding_reg, outstanding_next;
    logic              stopped_reg, stopped_next;
    logic              closed_reg, closed_next;
    logic [CW-1:0]     ceiling_reg;

    logic              p_valid_reg;
    cldf_pkg::meta_t   p_meta_reg, meta_next;
    logic              o_valid_reg;
    cldf_pkg::meta_t   o_meta_reg;
    logic [cldf_pkg::WORD_W-1:0] o_record_reg;

    cldf_pkg::cmd_t    cmd;
    logic              accept, o_load, wr_en, rd_en, admit_ok, cfg_we;
    logic [RW-1:0]     rd_data;
    logic [cldf_pkg::CMP_W-1:0] out_wide, drop_wide;

    assign cmd      = cldf_pkg::cmd_t'(s_tuser);
    assign o_load   = p_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || o_load;
    assign accept   = s_tvalid && s_tready;
    assign out_wide  = cldf_pkg::CMP_W'(outstanding_reg);
    assign drop_wide = cldf_pkg::CMP_W'(fill_reg);
    assign admit_ok  = (outstanding_reg < ceiling_reg)
                    && (fill_reg < FW'(cldf_pkg::QUEUE_DEPTH));

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        outstanding_next = outstanding_reg;
        stopped_next     = stopped_reg;
        closed_next      = closed_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        meta_next        = '0;
        meta_next.status = cldf_pkg::ST_OK;
        case (cmd)
            cldf_pkg::CMD_ADMIT:
            begin
                if (!admit_ok)
                    meta_next.status = cldf_pkg::ST_OVERFLOW;
                else
                begin
                    outstanding_next = outstanding_reg + 1'b1;
                    wr_en            = 1'b1;
                    tail_next        = cldf_pkg::ptr_advance(tail_reg);
                    fill_next        = fill_reg + 1'b1;
                end
            end
            cldf_pkg::CMD_TAKE:
            begin
                if (stopped_reg)
                    meta_next.status = cldf_pkg::ST_STOPPED;
                else if (fill_reg != '0)
                begin
                    rd_en             = 1'b1;
                    meta_next.take_ok = 1'b1;
                    head_next         = cldf_pkg::ptr_advance(head_reg);
                    fill_next         = fill_reg - 1'b1;
                end
                else if (closed_reg)
                    meta_next.status = cldf_pkg::ST_CLOSED_EMPTY;
                else
                    meta_next.status = cldf_pkg::ST_EMPTY_RETRY;
            end
            cldf_pkg::CMD_SETTLE:
            begin
                if (outstanding_reg != '0)
                    outstanding_next = outstanding_reg - 1'b1;
            end
            cldf_pkg::CMD_STOP:
                stopped_next = 1'b1;
            cldf_pkg::CMD_CLOSE:
                closed_next = 1'b1;
            cldf_pkg::CMD_DISCARD:
            begin
                meta_next.dropped = CW'(fill_reg);
                if (out_wide > drop_wide)
                    outstanding_next = CW'(out_wide - drop_wide);
                else
                    outstanding_next = '0;
                fill_next   = '0;
                head_next   = '0;
                tail_next   = '0;
                closed_next = 1'b1;
            end
            default:
            begin
                // unused command codes: no state change, status ok
            end
        endcase
        meta_next.outstanding = outstanding_next;
        meta_next.fill        = CW'(fill_next);
    end

    cldf_ram #(
        .WIDTH (RW),
        .DEPTH (cldf_pkg::QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && wr_en),
        .waddr (tail_reg),
        .wdata (s_tdata[RW-1:0]),
        .re    (accept && rd_en),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
            outstanding_reg <= '0;
            stopped_reg     <= 1'b0;
            closed_reg      <= 1'b0;
        end
        else if (accept)
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            fill_reg        <= fill_next;
            outstanding_reg <= outstanding_next;
            stopped_reg     <= stopped_next;
            closed_reg      <= closed_next;
        end
    end

    // read stage waits on RAM data, output register holds the finished beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                p_valid_reg <= 1'b1;
            else if (o_load)
                p_valid_reg <= 1'b0;
            if (o_load)
                o_valid_reg <= 1'b1;
            else if (m_tready)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            p_meta_reg <= meta_next;
        if (o_load)
        begin
            o_meta_reg   <= p_meta_reg;
            o_record_reg <= p_meta_reg.take_ok ? cldf_pkg::WORD_W'(rd_data) : '0;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_meta_reg.status;
    assign m_tdata  = {{cldf_pkg::PAD_W{1'b0}}, o_meta_reg.dropped, o_meta_reg.fill,
                       o_meta_reg.outstanding, o_record_reg};

    // configuration
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == cldf_pkg::REG_CEILING);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cldf_pkg::REG_CEILING) ? cldf_pkg::APB_W'(ceiling_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ceiling_reg <= cldf_pkg::CEILING_RESET;
        else if (cfg_we)
            ceiling_reg <= pwdata[CW-1:0];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(cldf_pkg::QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_discard_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd == cldf_pkg::CMD_DISCARD) |=> (fill_reg == '0) && closed_reg)
        else $error("discard left records or did not close");

    a_admit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd == cldf_pkg::CMD_ADMIT) && admit_ok
        |=> outstanding_reg == $past(outstanding_reg) + 1'b1)
        else $error("admit did not count the record");

    a_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && !o_load |=> p_valid_reg && $stable(p_meta_reg))
        else $error("read stage beat lost while output stalled");

endmodule
